// ===== src/urlpd_pkg.sv =====
`timescale 1ns / 1ps
// urlpd_pkg: types, character codes and helper functions for the URL percent decoder.
// Used by urlpd_if.sv, urlpd_step.sv and url_percent_decoder.sv; depends on nothing.
package urlpd_pkg;

	// Width of the saturating byte counter
	localparam int LENGTH_BITS = 16;
	localparam int REPORT_BITS = 16;

	localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};
	localparam logic [REPORT_BITS-1:0] REPORT_MAX = {REPORT_BITS{1'b1}};

	// Character codes
	localparam logic [7:0] CH_PLUS    = 8'h2B; // '+'
	localparam logic [7:0] CH_PERCENT = 8'h25; // '%'
	localparam logic [7:0] CH_UPPER_F = 8'h46; // 'F'
	localparam logic [7:0] CH_AMP     = 8'h26; // '&'
	localparam logic [7:0] CH_EQUAL   = 8'h3D; // '='
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// Escape phase
	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_FIRST  = 2'd1,
		PH_SECOND = 2'd2
	} phase_t;

	typedef struct packed {
		phase_t                 phase;
		logic [3:0]             high_nibble;
		logic                   first_upper_f;
		logic                   binary_flag;
		logic [LENGTH_BITS-1:0] byte_count;
	} state_t;

	localparam state_t STATE_RESET = '{PH_IDLE, 4'h0, 1'b0, 1'b0, {LENGTH_BITS{1'b0}}};

	// One result beat
	typedef struct packed {
		logic [7:0]             out_byte;
		logic                   has_byte;
		logic                   field_end;
		logic                   decode_error;
		logic [REPORT_BITS-1:0] decoded_length;
	} result_t;

	// Hex digit decode: bit 4 flags a valid digit, bits 3:0 its value
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'b0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	// Saturating increment of the byte counter
	function automatic logic [LENGTH_BITS-1:0] count_inc(input logic [LENGTH_BITS-1:0] n);
		return (n == COUNT_MAX) ? n : n + 1'b1;
	endfunction

	// Clamp the counter to the reported width
	function automatic logic [REPORT_BITS-1:0] report_len(input logic [LENGTH_BITS-1:0] n);
		logic [31:0] w;
		w = 32'(n);
		return (w > 32'(REPORT_MAX)) ? REPORT_MAX : w[REPORT_BITS-1:0];
	endfunction

endpackage

// ===== src/urlpd_if.sv =====
`timescale 1ns / 1ps
// urlpd_char_if / urlpd_res_if: valid/ready channels for characters and results.
// Depends on urlpd_pkg for the reported length width.
interface urlpd_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;

	modport source (output valid, output in_char, input ready);
	modport sink   (input valid, input in_char, output ready);
endinterface

interface urlpd_res_if;
	logic                             valid;
	logic                             ready;
	logic [7:0]                       out_byte;
	logic                             has_byte;
	logic                             field_end;
	logic                             decode_error;
	logic [urlpd_pkg::REPORT_BITS-1:0] decoded_length;

	modport source (output valid, output out_byte, output has_byte, output field_end,
		output decode_error, output decoded_length, input ready);
	modport sink   (input valid, input out_byte, input has_byte, input field_end,
		input decode_error, input decoded_length, output ready);
endinterface

// ===== src/urlpd_step.sv =====
`timescale 1ns / 1ps
// urlpd_step: one character of decoding: next state and the optional result beat.
// Purely combinational; depends on urlpd_pkg.
module urlpd_step (
	input  urlpd_pkg::state_t  state,
	input  logic [7:0]         in_char,
	output urlpd_pkg::state_t  next_state,
	output logic               emit,
	output urlpd_pkg::result_t result
);

	logic [4:0] hex;
	logic       is_term;

	assign hex     = urlpd_pkg::hex_decode(in_char);
	assign is_term = (in_char == urlpd_pkg::CH_AMP) || (in_char == urlpd_pkg::CH_EQUAL)
		|| (in_char == urlpd_pkg::CH_NUL);

	// Phase-driven decode
	always_comb begin
		next_state = state;
		emit       = 1'b0;
		result     = '0;
		unique case (state.phase)
			urlpd_pkg::PH_FIRST: begin
				if (!hex[4]) begin
					next_state          = urlpd_pkg::STATE_RESET;
					emit                = 1'b1;
					result.decode_error = 1'b1;
				end else begin
					next_state.high_nibble   = hex[3:0];
					next_state.first_upper_f = (in_char == urlpd_pkg::CH_UPPER_F);
					next_state.phase         = urlpd_pkg::PH_SECOND;
				end
			end
			urlpd_pkg::PH_SECOND: begin
				if (!hex[4]) begin
					next_state          = urlpd_pkg::STATE_RESET;
					emit                = 1'b1;
					result.decode_error = 1'b1;
				end else begin
					next_state.phase         = urlpd_pkg::PH_IDLE;
					next_state.first_upper_f = 1'b0;
					if (state.first_upper_f && in_char == urlpd_pkg::CH_UPPER_F) begin
						// uppercase %FF marks a binary field, no byte
						next_state.binary_flag = 1'b1;
					end else begin
						next_state.byte_count = urlpd_pkg::count_inc(state.byte_count);
						emit                  = 1'b1;
						result.out_byte       = {state.high_nibble, hex[3:0]};
						result.has_byte       = 1'b1;
					end
				end
			end
			default: begin
				next_state.phase = urlpd_pkg::PH_IDLE;
				if (in_char == urlpd_pkg::CH_PERCENT) begin
					next_state.phase = urlpd_pkg::PH_FIRST;
				end else if (is_term) begin
					// close the field: trailing zero counts unless binary
					next_state            = urlpd_pkg::STATE_RESET;
					emit                  = 1'b1;
					result.has_byte       = !state.binary_flag;
					result.field_end      = 1'b1;
					result.decoded_length = urlpd_pkg::report_len(state.binary_flag ?
						state.byte_count : urlpd_pkg::count_inc(state.byte_count));
				end else begin
					next_state.byte_count = urlpd_pkg::count_inc(state.byte_count);
					emit                  = 1'b1;
					result.has_byte       = 1'b1;
					result.out_byte       = (in_char == urlpd_pkg::CH_PLUS) ?
						urlpd_pkg::CH_SPACE : in_char;
				end
			end
		endcase
	end

endmodule

// ===== src/url_percent_decoder.sv =====
`timescale 1ns / 1ps
// url_percent_decoder: top level of the form-field percent decoder.
// Depends on urlpd_pkg, urlpd_if.sv (channel interfaces) and urlpd_step.
//
//  channel  | dir | payload                                                  | handshake
//  ---------+-----+----------------------------------------------------------+----------
//  chars    | in  | in_char[7:0]                                             | valid/ready
//  results  | out | out_byte, has_byte, field_end, decode_error, length[15:0]| valid/ready
//
// One character per cycle sustained while results are not stalled.
// The character is held in an input register, decoded in one pass against the
// escape state, and the result lands in the output register.
// A character that ends in no result ('%', first hex digit, %FF marker) uses one slot.
// Reset clears the escape state, counter and both valid bits.
// A stalled result holds the input register; chars.ready follows results.ready then.
module url_percent_decoder (
	input  logic                clk,
	input  logic                arst_n,
	urlpd_char_if.sink          chars,
	urlpd_res_if.source         results
);

	logic                 valid_s1;
	logic [7:0]           char_s1;
	urlpd_pkg::state_t    state_q;
	urlpd_pkg::state_t    next_state;
	urlpd_pkg::result_t   res_q;
	urlpd_pkg::result_t   step_res;
	logic                 out_valid_q;
	logic                 step_emit;
	logic                 advance;

	// Stage 1 moves on when the output slot is free or being drained
	assign advance     = valid_s1 && (!out_valid_q || results.ready);
	assign chars.ready = !valid_s1 || advance;

	urlpd_step u_step (
		.state      (state_q),
		.in_char    (char_s1),
		.next_state (next_state),
		.emit       (step_emit),
		.result     (step_res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.in_char;
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= urlpd_pkg::STATE_RESET;
		end else if (advance) begin
			state_q <= next_state;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step_emit;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_emit) begin
			res_q <= step_res;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.out_byte       = res_q.out_byte;
	assign results.has_byte       = res_q.has_byte;
	assign results.field_end      = res_q.field_end;
	assign results.decode_error   = res_q.decode_error;
	assign results.decoded_length = res_q.decoded_length;

	// An error beat carries nothing else
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.decode_error |->
			!res_q.has_byte && !res_q.field_end && res_q.decoded_length == '0)
		else $error("error beat carries payload");

	// A length is reported only on a field end
	a_len_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.field_end |-> res_q.decoded_length == '0)
		else $error("length outside field end");

	// Field end and error both return the state to reset
	a_state_reset: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_emit && (step_res.field_end || step_res.decode_error) |=>
			state_q == urlpd_pkg::STATE_RESET)
		else $error("state not reset after field close");

	// Back-pressure on the input only while stage 1 is occupied
	a_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!chars.ready |-> valid_s1 && out_valid_q && !results.ready)
		else $error("input stalled without cause");

	// A byte is emitted only with the counter moving or the field closing
	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_emit && step_res.has_byte && !step_res.field_end |=>
			state_q.byte_count == urlpd_pkg::count_inc($past(state_q.byte_count)))
		else $error("byte count did not track emitted byte");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for url_percent_decoder, one character beat in,
// zero or one result beat out. Depends on urlpd_pkg and the channel interfaces
// in urlpd_if.sv. A local decoder predicts each result.
module tb;

	localparam int CYCLE_LIMIT = 600_000;
	localparam int TAIL_CYCLES = 16;

	logic clk;
	logic arst_n;

	urlpd_char_if chars ();
	urlpd_res_if  results ();

	url_percent_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars),
		.results (results)
	);

	// Predicted decoder state
	urlpd_pkg::phase_t                 esc_phase;
	logic [3:0]                        esc_high;
	logic                              esc_upper_f;
	logic                              field_binary;
	logic [urlpd_pkg::LENGTH_BITS-1:0] field_count;

	urlpd_pkg::result_t pending_decodes[$];
	int                 mismatch_count;
	int                 chars_sent;
	int                 cycle_count;
	int                 send_idle_pct;
	int                 recv_idle_pct;

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// Hex digit check; v holds the digit value
	function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
		v = 4'h0;
		if (c >= "0" && c <= "9") begin
			v = 4'(c - "0");
			return 1'b1;
		end
		if (c >= "a" && c <= "f") begin
			v = 4'(c - "a" + 8'd10);
			return 1'b1;
		end
		if (c >= "A" && c <= "F") begin
			v = 4'(c - "A" + 8'd10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void clear_field();
		esc_phase    = urlpd_pkg::PH_IDLE;
		esc_high     = 4'h0;
		esc_upper_f  = 1'b0;
		field_binary = 1'b0;
		field_count  = '0;
	endfunction

	function automatic void bump_count();
		if (field_count != urlpd_pkg::COUNT_MAX)
			field_count++;
	endfunction

	// Decode one character; returns 1 when it produces a result beat
	function automatic bit decode_step(input logic [7:0] c, output urlpd_pkg::result_t r);
		logic [3:0]  nib;
		bit          is_hex;
		logic [63:0] len_wide;
		r = '0;
		is_hex = hex_digit(c, nib);
		case (esc_phase)
			urlpd_pkg::PH_FIRST: begin
				if (!is_hex) begin
					clear_field();
					r.decode_error = 1'b1;
					return 1'b1;
				end
				esc_high    = nib;
				esc_upper_f = (c == urlpd_pkg::CH_UPPER_F);
				esc_phase   = urlpd_pkg::PH_SECOND;
				return 1'b0;
			end
			urlpd_pkg::PH_SECOND: begin
				if (!is_hex) begin
					clear_field();
					r.decode_error = 1'b1;
					return 1'b1;
				end
				esc_phase = urlpd_pkg::PH_IDLE;
				// uppercase FF marks the field binary and yields nothing
				if (esc_upper_f && c == urlpd_pkg::CH_UPPER_F) begin
					esc_upper_f  = 1'b0;
					field_binary = 1'b1;
					return 1'b0;
				end
				esc_upper_f = 1'b0;
				bump_count();
				r.out_byte = {esc_high, nib};
				r.has_byte = 1'b1;
				return 1'b1;
			end
			default: begin
				esc_phase = urlpd_pkg::PH_IDLE;
				if (c == urlpd_pkg::CH_PERCENT) begin
					esc_phase = urlpd_pkg::PH_FIRST;
					return 1'b0;
				end
				if (c == urlpd_pkg::CH_AMP || c == urlpd_pkg::CH_EQUAL ||
						c == urlpd_pkg::CH_NUL) begin
					if (!field_binary)
						bump_count();
					r.has_byte  = !field_binary;
					r.field_end = 1'b1;
					len_wide    = 64'(field_count);
					r.decoded_length = (len_wide > 64'(urlpd_pkg::REPORT_MAX)) ?
						urlpd_pkg::REPORT_MAX : len_wide[urlpd_pkg::REPORT_BITS-1:0];
					clear_field();
					return 1'b1;
				end
				bump_count();
				r.out_byte = (c == urlpd_pkg::CH_PLUS) ? urlpd_pkg::CH_SPACE : c;
				r.has_byte = 1'b1;
				return 1'b1;
			end
		endcase
	endfunction

	// Send one character beat, with random idle cycles before it
	task automatic send_char(input logic [7:0] c);
		urlpd_pkg::result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			chars.valid <= 1'b0;
			@(posedge clk);
		end
		chars.valid   <= 1'b1;
		chars.in_char <= c;
		do
			@(posedge clk);
		while (!chars.ready);
		chars_sent++;
		if (decode_step(c, r))
			pending_decodes.push_back(r);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// Receiver stall pattern
	initial begin
		results.ready = 1'b0;
		forever begin
			@(posedge clk);
			results.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic log_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("tb: mismatch %0d at cycle %0d: %s", mismatch_count, cycle_count, msg);
	endtask

	task automatic check_result();
		urlpd_pkg::result_t want;
		urlpd_pkg::result_t got;
		got = '{results.out_byte, results.has_byte, results.field_end,
			results.decode_error, results.decoded_length};
		if (pending_decodes.size() == 0) begin
			log_mismatch($sformatf("unexpected beat byte=%h has=%b end=%b err=%b len=%0d",
				got.out_byte, got.has_byte, got.field_end, got.decode_error,
				got.decoded_length));
			return;
		end
		want = pending_decodes.pop_front();
		if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
				got.field_end !== want.field_end || got.decode_error !== want.decode_error ||
				got.decoded_length !== want.decoded_length)
			log_mismatch($sformatf(
				"exp byte=%h has=%b end=%b err=%b len=%0d, got byte=%h has=%b end=%b err=%b len=%0d",
				want.out_byte, want.has_byte, want.field_end, want.decode_error,
				want.decoded_length, got.out_byte, got.has_byte, got.field_end,
				got.decode_error, got.decoded_length));
	endtask

	// Result checker
	always @(posedge clk) begin
		if (arst_n && results.valid === 1'b1 && results.ready === 1'b1)
			check_result();
	end

	// Random character helpers
	function automatic logic [7:0] rand_plain_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (c == urlpd_pkg::CH_PERCENT || c == urlpd_pkg::CH_AMP ||
			c == urlpd_pkg::CH_EQUAL || c == urlpd_pkg::CH_NUL);
		return c;
	endfunction

	function automatic logic [7:0] rand_hex_char();
		int v;
		v = $urandom_range(15);
		if (v < 10)
			return 8'("0" + v);
		return ($urandom_range(1) != 0) ? 8'("A" + v - 10) : 8'("a" + v - 10);
	endfunction

	function automatic logic [7:0] rand_non_hex_char();
		logic [7:0] c;
		logic [3:0] v;
		case ($urandom_range(5))
			0: return urlpd_pkg::CH_AMP;
			1: return urlpd_pkg::CH_EQUAL;
			2: return urlpd_pkg::CH_NUL;
			default: begin
				do
					c = 8'($urandom_range(255));
				while (hex_digit(c, v));
				return c;
			end
		endcase
	endfunction

	// One field: random content, mostly well formed, then a terminator
	task automatic send_random_field();
		int tokens;
		int pick;
		tokens = $urandom_range(10);
		for (int i = 0; i < tokens; i++) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				send_char(rand_plain_char());
			end else if (pick < 55) begin
				send_char(urlpd_pkg::CH_PLUS);
			end else if (pick < 78) begin
				send_char(urlpd_pkg::CH_PERCENT);
				send_char(rand_hex_char());
				send_char(rand_hex_char());
			end else if (pick < 82) begin
				// case variants of FF: only the uppercase pair is the marker
				send_char(urlpd_pkg::CH_PERCENT);
				send_char(($urandom_range(1) != 0) ? "F" : "f");
				send_char(($urandom_range(1) != 0) ? "F" : "f");
			end else if (pick < 88) begin
				send_text("%FF");
			end else if (pick < 94) begin
				send_char(urlpd_pkg::CH_PERCENT);
				if ($urandom_range(1) != 0)
					send_char(rand_hex_char());
				send_char(rand_non_hex_char());
			end else begin
				send_char(8'($urandom_range(255)));
			end
		end
		case ($urandom_range(2))
			0: send_char(urlpd_pkg::CH_AMP);
			1: send_char(urlpd_pkg::CH_EQUAL);
			default: send_char(urlpd_pkg::CH_NUL);
		endcase
	endtask

	task automatic test_plain_and_plus();
		send_char("a");
		send_char(8'hFF);
		send_char(8'h80);
		send_char(8'h7F);
		send_char(urlpd_pkg::CH_PLUS);
		send_char(urlpd_pkg::CH_AMP);
	endtask

	task automatic test_escapes();
		send_text("%4a%fF%Ff");
		send_char(urlpd_pkg::CH_EQUAL);
	endtask

	task automatic test_binary_marker();
		send_text("%FFz");
		send_char(urlpd_pkg::CH_AMP);
	endtask

	task automatic test_malformed_escapes();
		send_text("%G");
		send_text("%1=");
		send_text("%&");
		// empty field closed by a zero byte
		send_char(urlpd_pkg::CH_NUL);
	endtask

	task automatic test_random(input int n);
		int target;
		target = chars_sent + n;
		while (chars_sent < target)
			send_random_field();
	endtask

	// Field long enough to saturate the byte counter, only for a narrow counter
	task automatic test_length_saturation();
		if (urlpd_pkg::LENGTH_BITS <= 8) begin
			for (longint i = 0; i < (64'd1 << urlpd_pkg::LENGTH_BITS); i++)
				send_char("x");
			send_char(urlpd_pkg::CH_AMP);
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		chars.valid    = 1'b0;
		chars.in_char  = 8'h00;
		mismatch_count = 0;
		chars_sent     = 0;
		send_idle_pct  = 32;
		recv_idle_pct  = 88;
		clear_field();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_and_plus();
		test_escapes();
		test_binary_marker();
		test_malformed_escapes();
		test_random(300);

		send_idle_pct = 88;
		recv_idle_pct = 32;
		test_random(250);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(250);
		test_length_saturation();
		chars.valid <= 1'b0;

		// drain, then allow for stray beats
		while (pending_decodes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_decodes.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// ===== url_percent_decoder.f =====
src/urlpd_pkg.sv
src/urlpd_if.sv
src/urlpd_step.sv
src/url_percent_decoder.sv
dv/tb.sv
